// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros: shared concurrent assertion macros
// Clocked assertions with asynchronous active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    `ASSERT_AT(lbl, clk, rstn, !(cond), msg)

`endif

// ----- design/ids_pkg.sv -----
// ----------------------------------------------------------------------------
// ids_pkg
// Shared types and constants of the indexed deque store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ids_pkg;

    localparam int CAPACITY_DEF = 256;

    localparam int OP_W      = 3;
    localparam int POS_W     = 16;
    localparam int DATA_W    = 64;
    localparam int CNT_OUT_W = 17;
    localparam int STAT_W    = 2;

    typedef enum logic [OP_W-1:0] {
        OP_SET        = 3'd0,
        OP_GET        = 3'd1,
        OP_PUSH_BACK  = 3'd2,
        OP_PUSH_FRONT = 3'd3,
        OP_POP_BACK   = 3'd4,
        OP_POP_FRONT  = 3'd5
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic clear_en;
        logic accept;
        logic exec;
    } ids_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic out_blocked;
    } ids_stat_t;

endpackage

`default_nettype wire

// ----- design/ids_ctrl.sv -----
// ----------------------------------------------------------------------------
// ids_ctrl
// Sequencer: clearing pass after reset, then accept / execute per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ids_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ids_pkg::ids_stat_t stat,
    output ids_pkg::ids_cmd_t      cmd
);
    import ids_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!stat.out_blocked)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd.clear_en = 1'b0;
        cmd.accept   = 1'b0;
        cmd.exec     = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_en = 1'b1;
            end
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            S_EXEC:
            begin
                // hold while the previous result is still waiting
                cmd.exec = !stat.out_blocked;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/ids_datapath.sv -----
// ----------------------------------------------------------------------------
// ids_datapath
// Ring memory, head and count registers, slot arithmetic and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ids_datapath #(
    parameter int CAPACITY = ids_pkg::CAPACITY_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire ids_pkg::ids_cmd_t              cmd,
    output ids_pkg::ids_stat_t                  stat,
    input  wire logic [ids_pkg::OP_W-1:0]       opcode,
    input  wire logic [ids_pkg::POS_W-1:0]      position,
    input  wire logic [ids_pkg::DATA_W-1:0]     data_word,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [ids_pkg::DATA_W-1:0]          read_word,
    output logic [ids_pkg::CNT_OUT_W-1:0]       count_after,
    output logic [ids_pkg::STAT_W-1:0]          status
);
    import ids_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [AW:0]          CAP_EXT   = (AW + 1)'(CAPACITY);
    localparam logic [AW-1:0]        LAST_SLOT = AW'(CAPACITY - 1);
    localparam logic [CNT_OUT_W-1:0] CAP_WIDE  = CNT_OUT_W'(CAPACITY);

    logic [DATA_W-1:0] store_mem [CAPACITY];

    logic [AW-1:0]     head_reg,  head_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     clr_reg;
    logic              out_valid_reg;

    op_t               op_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [DATA_W-1:0] data_reg;
    logic [AW-1:0]     slot_reg;
    logic [DATA_W-1:0] rdata_reg;

    logic [DATA_W-1:0] read_word_reg;
    logic [CW-1:0]     count_after_reg;
    status_t           status_reg;

    // slot selection at accept time
    logic [AW-1:0] idx;
    logic [AW:0]   slot_sum;
    logic [AW-1:0] slot_now;

    always_comb
    begin
        case (op_t'(opcode))
            OP_SET, OP_GET: idx = AW'(position);
            OP_PUSH_BACK:   idx = AW'(count_reg);
            OP_POP_BACK:    idx = AW'(count_reg - CW'(1));
            default:        idx = '0;
        endcase
        slot_sum = {1'b0, head_reg} + {1'b0, idx};
        if (slot_sum >= CAP_EXT)
        begin
            slot_now = AW'(slot_sum - CAP_EXT);
        end
        else
        begin
            slot_now = slot_sum[AW-1:0];
        end
        if (op_t'(opcode) == OP_PUSH_FRONT)
        begin
            slot_now = (head_reg == '0) ? LAST_SLOT : head_reg - AW'(1);
        end
    end

    // request execution
    logic [CNT_OUT_W-1:0] pos_wide;
    logic [CNT_OUT_W-1:0] count_wide;
    logic                 wr_en;
    logic [DATA_W-1:0]    wr_data;
    logic [DATA_W-1:0]    rd_value;
    status_t              st_value;
    logic                 pop_ok;

    assign pos_wide   = CNT_OUT_W'(pos_reg);
    assign count_wide = CNT_OUT_W'(count_reg);

    always_comb
    begin
        wr_en      = 1'b0;
        wr_data    = data_reg;
        rd_value   = '0;
        st_value   = STATUS_OK;
        count_next = count_reg;
        head_next  = head_reg;
        pop_ok     = 1'b0;
        case (op_reg)
            OP_SET:
            begin
                if (pos_wide >= CAP_WIDE)
                begin
                    st_value = STATUS_FULL;
                end
                else
                begin
                    wr_en = 1'b1;
                    if (pos_wide >= count_wide)
                    begin
                        count_next = CW'(pos_wide + CNT_OUT_W'(1));
                    end
                end
            end
            OP_GET:
            begin
                if (pos_wide < count_wide)
                begin
                    rd_value = rdata_reg;
                end
            end
            OP_PUSH_BACK, OP_PUSH_FRONT:
            begin
                if (count_wide == CAP_WIDE)
                begin
                    st_value = STATUS_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                    if (op_reg == OP_PUSH_FRONT)
                    begin
                        head_next = slot_reg;
                    end
                end
            end
            OP_POP_BACK, OP_POP_FRONT:
            begin
                if (count_reg == '0)
                begin
                    st_value = STATUS_EMPTY;
                end
                else
                begin
                    pop_ok     = 1'b1;
                    rd_value   = rdata_reg;
                    wr_en      = 1'b1;
                    wr_data    = '0;
                    count_next = count_reg - CW'(1);
                    if (op_reg == OP_POP_FRONT)
                    begin
                        head_next = (slot_reg == LAST_SLOT) ? '0 : slot_reg + AW'(1);
                    end
                end
            end
            default:
            begin
                st_value = STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_en)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.exec)
            begin
                head_reg      <= head_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request payload and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= op_t'(opcode);
            pos_reg  <= position;
            data_reg <= data_word;
            slot_reg <= slot_now;
        end
        if (cmd.exec)
        begin
            read_word_reg   <= rd_value;
            count_after_reg <= count_next;
            status_reg      <= st_value;
        end
    end

    // single-port ring memory, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.clear_en)
        begin
            store_mem[clr_reg] <= '0;
        end
        else if (cmd.exec && wr_en)
        begin
            store_mem[slot_reg] <= wr_data;
        end
        if (cmd.accept)
        begin
            rdata_reg <= store_mem[slot_now];
        end
    end

    assign stat.clear_last  = (clr_reg == LAST_SLOT);
    assign stat.out_blocked = out_valid_reg && !out_ready;

    assign out_valid   = out_valid_reg;
    assign read_word   = read_word_reg;
    assign count_after = CNT_OUT_W'(count_after_reg);
    assign status      = status_reg;

    `ASSERT_NEVER(a_count_bound, clk, rst_n, CNT_OUT_W'(count_reg) > CAP_WIDE, "count above capacity")
    `ASSERT_NEVER(a_head_bound, clk, rst_n, {1'b0, head_reg} >= CAP_EXT, "head outside ring")
    `ASSERT_NEVER(a_no_overwrite, clk, rst_n, cmd.exec && out_valid_reg && !out_ready, "result overwritten")
    `ASSERT_AT(a_result_follows, clk, rst_n, cmd.exec |=> out_valid_reg, "result not presented")
    `ASSERT_AT(a_pop_shrinks, clk, rst_n, (cmd.exec && pop_ok) |=> (count_reg == $past(count_reg) - CW'(1)), "pop did not shrink count")

endmodule

`default_nettype wire

// ----- design/indexed_deque_store.sv -----
// ----------------------------------------------------------------------------
// indexed_deque_store
// Fixed-capacity double-ended array of 64-bit words with indexed set / get.
// ----------------------------------------------------------------------------
//  channel   handshake              fields
//  request   in_valid / in_ready    opcode, position, data_word
//  result    out_valid / out_ready  read_word, count_after, status
//
//  each request is accepted, which reads the ring memory, and then executed,
//  which writes it and updates head, count and the result register
//  the single-port ring memory and the head / count dependency keep one request in flight
//  after reset a clearing pass zeroes the memory, with in_ready low
//  a result not yet taken holds the execute step until out_ready frees it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module indexed_deque_store #(
    parameter int CAPACITY = ids_pkg::CAPACITY_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [ids_pkg::OP_W-1:0]       opcode,
    input  wire logic [ids_pkg::POS_W-1:0]      position,
    input  wire logic [ids_pkg::DATA_W-1:0]     data_word,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [ids_pkg::DATA_W-1:0]          read_word,
    output logic [ids_pkg::CNT_OUT_W-1:0]       count_after,
    output logic [ids_pkg::STAT_W-1:0]          status
);
    import ids_pkg::*;

    ids_cmd_t  cmd;
    ids_stat_t stat;

    ids_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ids_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .opcode      (opcode),
        .position    (position),
        .data_word   (data_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_word   (read_word),
        .count_after (count_after),
        .status      (status)
    );

endmodule

`default_nettype wire
